[design/olist_pkg.sv]
`default_nettype none

package olist_pkg;

  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 5;
  // A readout sends at most this many transfers
  localparam int MAX_RESULTS = 16;

  // Operation codes carried on in_tuser
  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_SORTED     = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_DEL_VALUE  = 3'd4,
    MODE_DEL_AFTER  = 3'd5,
    MODE_READOUT    = 3'd6
  } mode_t;

  // Result status carried on out_tuser
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // What a cell loads on the next edge
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_KEY,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_HEAD
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_POS,
    S_EXEC,
    S_READ
  } state_t;

endpackage

`default_nettype wire

[design/olist_cell.sv]
`default_nettype none

module olist_cell
  import olist_pkg::*;
(
  input  wire                       clk,
  input  wire cell_op_t             op,
  input  wire logic [VALUE_W-1:0]   key,
  input  wire logic [VALUE_W-1:0]   left_val,
  input  wire logic [VALUE_W-1:0]   right_val,
  input  wire logic [VALUE_W-1:0]   head_val,
  output logic      [VALUE_W-1:0]   val,
  output logic                      eq,
  output logic                      ge
);

  logic [VALUE_W-1:0] val_r;
  logic [VALUE_W-1:0] val_nxt;

  // Neighbor select
  always_comb begin
    case (op)
      CELL_KEY:   val_nxt = key;
      CELL_LEFT:  val_nxt = left_val;
      CELL_RIGHT: val_nxt = right_val;
      CELL_HEAD:  val_nxt = head_val;
      default:    val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  // Local compares against the broadcast key
  assign val = val_r;
  assign eq  = (val_r == key);
  assign ge  = ($signed(val_r) >= $signed(key));

endmodule

`default_nettype wire

[design/olist_scan.sv]
`default_nettype none

// Log-depth prefix OR: pre[i] is set when any flag below i is set,
// first[i] marks the lowest set flag.
module olist_scan #(
  parameter int N = 16
) (
  input  wire logic [N-1:0] flags,
  output logic      [N-1:0] first,
  output logic      [N-1:0] pre
);

  localparam int LVLS = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [0:LVLS];

  assign lvl[0] = flags;

  for (genvar k = 0; k < LVLS; k++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1 << k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  // Exclusive prefix from the inclusive one
  assign pre   = {lvl[LVLS][N-2:0], 1'b0};
  assign first = flags & ~pre;

endmodule

`default_nettype wire

[design/ordered_value_list_core.sv]
// Ordered value list core.
// Input channel (in_*): one transfer per operation; in_tuser carries the
// operation code, in_tdata the value to insert or the key to search for.
// Output channel (out_*): out_tuser carries the status, out_tdata the
// affected value and the entry count after the operation, out_tlast marks
// the final transfer of an operation.
// The list lives in a row of CAPACITY cells, front in cell 0. Inserts and
// deletes shift the cells behind the position by one, all together;
// the position comes from a log-depth prefix scan over the cell compares.
// Insert/delete: the operation passes S_CMP (compare), S_POS (scan) and
// S_EXEC (update, held while the output is stalled), then returns to idle;
// no new item is taken before that. Readout: the cells rotate one step per
// cycle while the output is not stalled, cell 0 feeding the output; up to
// 16 transfers are sent. Opcode seven is dropped without a result.
// A one-deep output register holds a finished result; in_tready is high
// whenever the core is idle, even while that result waits. A stalled
// receiver freezes the update or the rotation until out_tready returns.
// Synchronous reset empties the list and clears out_tvalid; entry
// contents are not cleared.
`default_nettype none

module ordered_value_list_core
  import olist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] value
  input  wire  [2:0]  in_tuser,   // [2:0] mode
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // [31:0] item_value, [36:32] entry_count
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int NOUT = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

  state_t             state_r, state_nxt;
  mode_t              mode_r;
  logic [VALUE_W-1:0] key_r;
  logic [LW-1:0]      len_r, len_nxt;
  logic [LW-1:0]      rd_cnt_r, rd_cnt_nxt;

  logic [CAPACITY-1:0] f_cmp, f_r;
  logic [CAPACITY-1:0] first_c, pre_c;
  logic [CAPACITY-1:0] m_r, pre_r;
  logic [CAPACITY-1:0] cell_eq, cell_ge;
  logic [CAPACITY-1:0] tgt, rm;

  cell_op_t           cell_op  [CAPACITY];
  logic [VALUE_W-1:0] cell_val [CAPACITY];
  logic [VALUE_W-1:0] rm_val;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic               out_free;
  logic               emit;

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left_v, right_v;
    if (i == 0) begin : g_head
      assign left_v = key_r;
    end else begin : g_mid
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = cell_val[0];
    end else begin : g_body
      assign right_v = cell_val[i+1];
    end
    olist_cell u_cell (
      .clk       (clk),
      .op        (cell_op[i]),
      .key       (key_r),
      .left_val  (left_v),
      .right_val (right_v),
      .head_val  (cell_val[0]),
      .val       (cell_val[i]),
      .eq        (cell_eq[i]),
      .ge        (cell_ge[i])
    );
  end

  // Per-cell match flags for the current operation
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      case (mode_r)
        MODE_PUSH_FRONT, MODE_POP_FRONT: f_cmp[i] = (i == 0);
        MODE_PUSH_BACK:  f_cmp[i] = (LW'(i) == len_r);
        MODE_SORTED:     f_cmp[i] = (cell_ge[i] && (LW'(i) < len_r)) || (LW'(i) == len_r);
        MODE_DEL_VALUE, MODE_DEL_AFTER: f_cmp[i] = cell_eq[i] && (LW'(i) < len_r);
        default:         f_cmp[i] = 1'b0;
      endcase
    end
  end

  olist_scan #(.N(CAPACITY)) u_scan (
    .flags (f_r),
    .first (first_c),
    .pre   (pre_c)
  );

  // Flag and position pipeline (free running, cells are frozen meanwhile)
  always_ff @(posedge clk) begin
    f_r   <= f_cmp;
    m_r   <= first_c;
    pre_r <= pre_c;
  end

  // Removal target and shift mask
  always_comb begin
    if (mode_r == MODE_DEL_AFTER) begin
      tgt[0] = 1'b0;
      for (int i = 1; i < CAPACITY; i++) begin
        tgt[i] = m_r[i-1] && (LW'(i) < len_r);
      end
      rm = pre_r;
    end else begin
      tgt = m_r;
      rm  = pre_r | m_r;
    end
  end

  // Value of the removed entry
  always_comb begin
    rm_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rm_val = rm_val | (tgt[i] ? cell_val[i] : '0);
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign emit     = (rd_cnt_r < LW'(NOUT));

  // Control: next state, cell commands, result register
  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    rd_cnt_nxt     = rd_cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_count_nxt  = out_count_r;
    in_tready      = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op[i] = CELL_HOLD;
    end

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        rd_cnt_nxt = '0;
        case (mode_r)
          MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_SORTED,
          MODE_POP_FRONT, MODE_DEL_VALUE, MODE_DEL_AFTER: state_nxt = S_POS;
          MODE_READOUT: state_nxt = (len_r == '0) ? S_EXEC : S_READ;
          default:      state_nxt = S_IDLE;
        endcase
      end
      S_POS: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_value_nxt = '0;
          case (mode_r)
            MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_SORTED: begin
              if (len_r == LW'(CAPACITY)) begin
                out_status_nxt = ST_FULL;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (m_r[i]) begin
                    cell_op[i] = CELL_KEY;
                  end else if (pre_r[i]) begin
                    cell_op[i] = CELL_LEFT;
                  end
                end
                len_nxt        = len_r + LW'(1);
                out_status_nxt = ST_OK;
                out_value_nxt  = key_r;
              end
            end
            MODE_POP_FRONT, MODE_DEL_VALUE, MODE_DEL_AFTER: begin
              if (len_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else if (|tgt) begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (rm[i]) begin
                    cell_op[i] = CELL_RIGHT;
                  end
                end
                len_nxt        = len_r - LW'(1);
                out_status_nxt = ST_OK;
                out_value_nxt  = rm_val;
              end else begin
                out_status_nxt = ST_MISS;
              end
            end
            default: begin
              // readout of an empty list
              out_status_nxt = ST_EMPTY;
            end
          endcase
          out_count_nxt = COUNT_W'(len_nxt);
        end
      end
      S_READ: begin
        // Rotate the occupied cells one step; cell 0 feeds the output
        if (!emit || out_free) begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (LW'(i) == len_r - LW'(1)) begin
              cell_op[i] = CELL_HEAD;
            end else if (LW'(i) < len_r) begin
              cell_op[i] = CELL_RIGHT;
            end
          end
          if (emit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_value_nxt  = cell_val[0];
            out_last_nxt   = (rd_cnt_r == len_r - LW'(1)) || (rd_cnt_r == LW'(NOUT - 1));
            out_count_nxt  = COUNT_W'(len_r);
          end
          if (rd_cnt_r == len_r - LW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            rd_cnt_nxt = rd_cnt_r + LW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r <= mode_t'(in_tuser);
      key_r  <= in_tdata;
    end
    rd_cnt_r     <= rd_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_count_r, out_value_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[design/olist_checker.sv]
`default_nettype none

module olist_checker
  import olist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [39:0] out_tdata,
  input wire [1:0]  out_tuser,
  input wire        out_tlast
);

  // One operation at a time: busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while previous operation in flight");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Failed operations carry a zero value and end the operation
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[31:0] == 32'd0 && out_tlast)
    else $error("failed status with nonzero value or without tlast");

  // Status agrees with the entry count
  a_count_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != ST_FULL || out_tdata[36:32] == 5'(CAPACITY)) &&
      (out_tuser != ST_EMPTY || out_tdata[36:32] == 5'd0))
    else $error("entry count disagrees with status");

endmodule

bind ordered_value_list_core olist_checker #(.CAPACITY(CAPACITY)) u_olist_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
